// File: rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Depends on nothing; every RTL file of the hasher imports it.
`timescale 1ns / 1ps

package sha256_pkg;

    // One input word: a message byte with its presence and end marks.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       last_byte;
    } in_word_t;

    // One result word: the 256-bit digest, big-endian across four fields.
    typedef struct packed {
        logic [63:0] digest_word_a;
        logic [63:0] digest_word_b;
        logic [63:0] digest_word_c;
        logic [63:0] digest_word_d;
    } out_word_t;

    // First padding byte and the offset at which the length field starts.
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_OFFSET  = 6'd56;
    localparam logic [5:0] LAST_SLOT   = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    // Standard initial hash values.
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Round functions on the working variables.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule functions.
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer,
// one shared round unit and the digest output register. Uses sha256_pkg.
`timescale 1ns / 1ps

// SHA-256 over a byte stream, one byte per input word. The byte that
// completes a 64-byte block starts the single shared round unit, which runs
// 64 rounds, one a cycle, and then folds the result into the chaining
// value. A word marked last starts the padding sequencer, which pushes the
// pad bytes and the bit length through the same byte path at one byte a
// cycle and then runs one or two more compressions. The block is not ready
// while it compresses or pads. The digest sits in an output register, and
// the next message can stream in while it waits; only the next digest
// waits for the previous one to be taken.
module sha256_stream_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_word_t out_data
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        spill_reg, spill_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] wv_reg [8];
    logic [31:0] wv_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    out_word_t   out_data_reg, out_data_next;

    logic        in_fire;
    logic        ins_en;
    logic [7:0]  ins_byte;
    logic [7:0]  len_byte;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;
    logic [31:0] sched_new;
    logic        final_block;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Length field byte for slot 56 + k is bits 63-8k down to 56-8k.
    assign len_byte = 8'(bit_len_reg >> {~fill_reg[2:0], 3'b000});

    // The last compression of a message is the one after the length bytes.
    assign final_block = pad_reg && mark_reg && !spill_reg;

    // Shared round unit: while rounds run, the schedule line holds W[t..t+15].
    always_comb
    begin
        ch_val    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj_val   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                  ^ (wv_reg[1] & wv_reg[2]);
        t1        = wv_reg[7] + big_sigma1(wv_reg[4]) + ch_val + ROUND_K[round_reg]
                  + w_reg[0];
        t2        = big_sigma0(wv_reg[0]) + maj_val;
        sched_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    end

    // Sequencer: intake, padding, rounds, chaining update and output.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        bit_len_next   = bit_len_reg;
        pad_next       = pad_reg;
        mark_next      = mark_reg;
        spill_next     = spill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        chain_next     = chain_reg;
        wv_next        = wv_reg;
        w_next         = w_reg;
        ins_en         = 1'b0;
        ins_byte       = in_data.msg_byte;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pad_next = in_data.last_byte;
                    if (in_data.byte_present)
                    begin
                        ins_en       = 1'b1;
                        bit_len_next = bit_len_reg + 64'd8;
                    end
                    if (in_data.byte_present && fill_reg == LAST_SLOT)
                    begin
                        state_next = S_COMP;
                    end
                    else if (in_data.last_byte)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ins_en    = 1'b1;
                mark_next = 1'b1;
                if (!mark_reg)
                begin
                    ins_byte = PAD_MARK;
                    // Marker lands past the length slot: a second block follows.
                    if (fill_reg >= LEN_OFFSET)
                    begin
                        spill_next = 1'b1;
                    end
                end
                else if (spill_reg || fill_reg < LEN_OFFSET)
                begin
                    ins_byte = 8'h00;
                end
                else
                begin
                    ins_byte = len_byte;
                end
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                for (int k = 0; k < 15; k++)
                begin
                    w_next[k] = w_reg[k + 1];
                end
                w_next[15] = sched_new;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    chain_next[k] = chain_reg[k] + wv_reg[k];
                end
                if (final_block)
                begin
                    state_next = S_OUT;
                end
                else if (pad_reg)
                begin
                    spill_next = 1'b0;
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{digest_word_a: {chain_reg[0], chain_reg[1]},
                                       digest_word_b: {chain_reg[2], chain_reg[3]},
                                       digest_word_c: {chain_reg[4], chain_reg[5]},
                                       digest_word_d: {chain_reg[6], chain_reg[7]}};
                    chain_next     = INIT_HASH;
                    bit_len_next   = 64'd0;
                    fill_next      = 6'd0;
                    pad_next       = 1'b0;
                    mark_next      = 1'b0;
                    spill_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Byte path: the schedule line doubles as the block buffer.
        if (ins_en)
        begin
            for (int k = 0; k < 15; k++)
            begin
                w_next[k] = {w_reg[k][23:0], w_reg[k + 1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], ins_byte};
            fill_next  = fill_reg + 6'd1;
            if (fill_reg == LAST_SLOT)
            begin
                wv_next = chain_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= 6'd0;
            round_reg     <= 6'd0;
            bit_len_reg   <= 64'd0;
            pad_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            spill_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= INIT_HASH;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            bit_len_reg   <= bit_len_next;
            pad_reg       <= pad_next;
            mark_reg      <= mark_next;
            spill_reg     <= spill_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        wv_reg       <= wv_next;
        w_reg        <= w_next;
        out_data_reg <= out_data_next;
    end

    // The round counter only moves while rounds run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COMP) |-> (round_reg == 6'd0))
        else $error("round counter left nonzero outside compression");

    // A block is complete whenever the round unit runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (fill_reg == 6'd0))
        else $error("compression running with a partial block");

    // A spilled tail only exists after the marker byte of a padded message.
    assert property (@(posedge clk) disable iff (!rst_n)
        spill_reg |-> (pad_reg && mark_reg))
        else $error("spill flag set outside padding");

    // An end word without a byte goes straight to padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_byte && !in_data.byte_present) |=> (state_reg == S_PAD))
        else $error("byte-free end word did not start padding");

    // A digest is only loaded from the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("digest loaded outside the output state");

endmodule
